[hw/rtl/xltt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the line tag tokenizer.
// No dependencies; used by xltt_front, xltt_queue and xml_line_tag_tokenizer.
package xltt_pkg;

	typedef enum logic [2:0] {
		KIND_TAG_CHAR   = 3'd0,
		KIND_ATTR_NAME  = 3'd1,
		KIND_ATTR_VALUE = 3'd2,
		KIND_ATTR_DONE  = 3'd3,
		KIND_TAG_END    = 3'd4
	} event_kind_t;

	// One result event as it travels from the front to the output queue.
	typedef struct packed {
		logic        is_closing;
		event_kind_t event_kind;
		logic [7:0]  char_out;
	} event_t;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam int QUEUE_DEPTH = 2;

endpackage

[hw/rtl/xltt_front.sv]
`timescale 1ns / 1ps
// Front end: takes one byte per request, tracks line/tag state, classifies
// the byte into at most one event. Depends on xltt_pkg.
module xltt_front import xltt_pkg::*; #(
	parameter int MAX_LINE_LENGTH = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,      // byte accepted this cycle
	input  logic [7:0] char_in,
	output logic       ev_valid,  // event produced by the accepted byte
	output event_t     ev
);

	localparam int PosW = (MAX_LINE_LENGTH > 2) ? $clog2(MAX_LINE_LENGTH) : 1;
	localparam logic [PosW-1:0] MaxPos = PosW'(MAX_LINE_LENGTH - 1);

	logic [PosW-1:0] pos_q, lob_q;
	logic closing_q, ended_q, lead_q, name_q, rav_q, inq_q;

	logic [PosW-1:0] pos_n, lob_n;
	logic closing_n, ended_n, lead_n, name_n, rav_n, inq_n;

	always_comb begin
		pos_n     = pos_q;
		lob_n     = lob_q;
		closing_n = closing_q;
		ended_n   = ended_q;
		lead_n    = lead_q;
		name_n    = name_q;
		rav_n     = rav_q;
		inq_n     = inq_q;
		ev_valid  = 1'b0;
		ev        = '0;

		if (char_in == CH_CR || char_in == CH_LF) begin
			if (!ended_q) begin
				ended_n       = 1'b1;
				ev_valid      = 1'b1;
				ev.event_kind = KIND_TAG_END;
				ev.is_closing = closing_q;
			end
		end else begin
			if (ended_q) begin
				// first byte of a new line
				ended_n   = 1'b0;
				pos_n     = '0;
				lob_n     = '0;
				closing_n = 1'b0;
				lead_n    = 1'b0;
				name_n    = 1'b0;
				rav_n     = 1'b0;
				inq_n     = 1'b0;
			end
			if (!(ended_q && char_in == CH_SPACE)) begin
				if (char_in == CH_LT)
					lob_n = pos_n;
				else if (char_in == CH_SLASH && ({1'b0, lob_n} + 1'b1) == {1'b0, pos_n})
					closing_n = 1'b1;
				if (pos_n < MaxPos)
					pos_n = pos_n + 1'b1;

				if (!lead_n && char_in == CH_SPACE) begin
					// leading space, nothing
				end else begin
					lead_n = 1'b1;
					if (!name_n) begin
						if (char_in == CH_SPACE)
							name_n = 1'b1;
						else if (!(char_in == CH_LT || char_in == CH_SLASH ||
						           char_in == CH_GT || char_in == CH_QMARK)) begin
							ev_valid      = 1'b1;
							ev.event_kind = KIND_TAG_CHAR;
							ev.char_out   = char_in;
						end
					end else if (!rav_n) begin
						if (char_in == CH_EQ)
							rav_n = 1'b1;
						else if (char_in != CH_SPACE) begin
							ev_valid      = 1'b1;
							ev.event_kind = KIND_ATTR_NAME;
							ev.char_out   = char_in;
						end
					end else if (char_in == CH_QUOTE) begin
						inq_n = !inq_n;
						if (inq_q == 1'b1 || !inq_n) begin
							rav_n         = 1'b0;
							ev_valid      = 1'b1;
							ev.event_kind = KIND_ATTR_DONE;
						end
					end else if (inq_n) begin
						ev_valid      = 1'b1;
						ev.event_kind = KIND_ATTR_VALUE;
						ev.char_out   = char_in;
					end
				end
			end
		end
		if (!take)
			ev_valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			lob_q     <= '0;
			closing_q <= 1'b0;
			ended_q   <= 1'b0;
			lead_q    <= 1'b0;
			name_q    <= 1'b0;
			rav_q     <= 1'b0;
			inq_q     <= 1'b0;
		end else if (take) begin
			pos_q     <= pos_n;
			lob_q     <= lob_n;
			closing_q <= closing_n;
			ended_q   <= ended_n;
			lead_q    <= lead_n;
			name_q    <= name_n;
			rav_q     <= rav_n;
			inq_q     <= inq_n;
		end
	end

	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= MaxPos) else $error("line position past saturation");
	a_rav_name: assert property (@(posedge clk) disable iff (!arst_n)
		rav_q |-> name_q) else $error("attribute value without finished tag name");
	a_inq_rav: assert property (@(posedge clk) disable iff (!arst_n)
		inq_q |-> rav_q) else $error("inside quotes outside attribute value");

endmodule

[hw/rtl/xltt_queue.sv]
`timescale 1ns / 1ps
// Back end: short event queue whose head drives the output stream.
// Depends on xltt_pkg.
module xltt_queue import xltt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  event_t push_ev,
	output logic   full,
	output logic   out_valid,
	input  logic   out_ready,
	output event_t out_ev
);

	localparam int PtrW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CntW-1:0] Depth = CntW'(QUEUE_DEPTH);
	localparam logic [PtrW-1:0] LastIdx = PtrW'(QUEUE_DEPTH - 1);

	event_t          mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] count_q;
	logic            pop;

	assign full      = (count_q == Depth);
	assign out_valid = (count_q != '0);
	assign out_ev    = mem_q[rd_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == LastIdx) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("push into full queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Depth) else $error("queue count out of range");
	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count did not drop on pop");

endmodule

[hw/rtl/xml_line_tag_tokenizer.sv]
`timescale 1ns / 1ps
// Top level of the line tag tokenizer: front classifier plus output queue.
// Depends on xltt_pkg, xltt_front, xltt_queue.
//
//  channel | dir | tdata        | tuser (low bit up)
//  --------+-----+--------------+--------------------------------
//  s_*     | in  | char_in[7:0] | -
//  m_*     | out | char_out[7:0]| event_kind[2:0], is_closing[3]
//
// Each byte is classified in the cycle its request is accepted; the event, if
// any, is registered into a two-entry queue whose head is offered on m_*.
// Throughput is one byte per cycle while the queue has room.
// s_tready drops only while the queue holds two undelivered events, so the
// input side stalls only under output backpressure.
// arst_n clears all line state and empties the queue; no clearing pass.
module xml_line_tag_tokenizer import xltt_pkg::*; #(
	parameter int MAX_LINE_LENGTH = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_in
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] char_out
	output logic [3:0] m_tuser    // [2:0] event_kind, [3] is_closing
);

	logic   q_full;
	logic   take;
	logic   ev_valid;
	event_t ev;
	event_t head;

	// accept whenever the queue has room
	assign s_tready = !q_full;
	assign take     = s_tvalid && s_tready;

	xltt_front #(
		.MAX_LINE_LENGTH(MAX_LINE_LENGTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.char_in (s_tdata),
		.ev_valid(ev_valid),
		.ev      (ev)
	);

	xltt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (ev_valid),
		.push_ev  (ev),
		.full     (q_full),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_ev   (head)
	);

	assign m_tdata = head.char_out;
	assign m_tuser = {head.is_closing, head.event_kind};

endmodule
